// ===== rtl/swst_pkg.sv =====
// Shared types and constants for the sensor wait subscription table.
// No dependencies; imported by the top level and its checker.
`timescale 1ns / 1ps

package swst_pkg;

    localparam int TABLE_DEPTH = 8;
    localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int WAITER_W    = 3;
    localparam int WORD_W      = 32;
    localparam int WAKE_W      = 5;
    localparam logic [WAITER_W-1:0] WAITER_MAX = WAITER_W'(5);

    typedef enum logic [1:0] {
        SUB_NONE   = 2'd0,
        SUB_STORED = 2'd1,
        SUB_DUP    = 2'd2,
        SUB_FULL   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic [WAITER_W-1:0] waiter;
        logic [WORD_W-1:0]   mask;
        logic [WORD_W-1:0]   expect_val;
    } entry_t;

endpackage

// ===== rtl/sensor_wait_subscription_table.sv =====
// Top level of the sensor wait subscription table: entry memory, scan sequencer
// and output register. Depends on swst_pkg.
`timescale 1ns / 1ps

// Each input beat is one polling period carrying an optional subscription
// (waiter id 1..5, sensor mask, expected state) and the current sensor word;
// each produces exactly one output beat with a wake vector and a subscription
// status (none, stored, duplicate, table full). Entries live in a single-port
// synchronous memory of TABLE_DEPTH words; occupancy is held in one flip-flop
// per slot, so reset empties the table at once with no clearing pass. Per item
// the scan issues one memory read per slot and handles the last read data in
// its final step; the finish step then applies the store and the clears once
// the output register is free or taken. The sweep checks each occupied slot
// for an exact duplicate and for a sensor match, and notes the lowest empty
// slot; a new subscription's own match is checked from the beat itself. The
// input is stalled while an item is being processed; a finished result may
// wait in the output register while the next beat is accepted and swept.
module sensor_wait_subscription_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          sub_valid,
    input  logic [swst_pkg::WAITER_W-1:0] sub_waiter,
    input  logic [swst_pkg::WORD_W-1:0]   sub_mask,
    input  logic [swst_pkg::WORD_W-1:0]   sub_expect,
    input  logic [swst_pkg::WORD_W-1:0]   sensor_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [swst_pkg::WAKE_W-1:0]   wake_vector,
    output logic [1:0]                    sub_status
);
    import swst_pkg::*;

    // entry memory, contents valid only where occ_reg is set
    entry_t mem [TABLE_DEPTH];

    // control
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   rd_vld_reg, rd_vld_next;
    logic [TABLE_DEPTH-1:0] occ_reg, occ_next;
    logic                   out_valid_reg, out_valid_next;

    // captured beat
    logic                   sub_vld_reg, sub_vld_next;
    entry_t                 sub_reg, sub_next;
    logic [WORD_W-1:0]      sensor_reg, sensor_next;

    // sweep accumulators
    logic [SLOT_W-1:0]      rd_slot_reg;
    entry_t                 rd_data_reg;
    logic                   dup_reg, dup_next;
    logic                   have_free_reg, have_free_next;
    logic [SLOT_W-1:0]      free_slot_reg, free_slot_next;
    logic [WAKE_W-1:0]      wake_reg, wake_next;
    logic [TABLE_DEPTH-1:0] clr_reg, clr_next;

    // output payload
    logic [WAKE_W-1:0]      wake_out_reg, wake_out_next;
    status_t                status_out_reg, status_out_next;

    // memory port
    logic                   rd_en;
    logic [SLOT_W-1:0]      rd_addr;
    logic                   mem_we;

    logic                   waiter_ok;
    logic                   new_match;
    logic                   slot_match;
    logic                   slot_dup;

    assign rd_addr    = cnt_reg[SLOT_W-1:0];
    assign waiter_ok  = (sub_reg.waiter != '0) && (sub_reg.waiter <= WAITER_MAX);
    assign new_match  = ((sensor_reg & sub_reg.mask) == sub_reg.expect_val);
    assign slot_match = ((sensor_reg & rd_data_reg.mask) == rd_data_reg.expect_val);
    assign slot_dup   = (rd_data_reg == sub_reg);

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        rd_vld_next     = 1'b0;
        rd_en           = 1'b0;
        mem_we          = 1'b0;
        occ_next        = occ_reg;
        out_valid_next  = out_valid_reg;
        sub_vld_next    = sub_vld_reg;
        sub_next        = sub_reg;
        sensor_next     = sensor_reg;
        dup_next        = dup_reg;
        have_free_next  = have_free_reg;
        free_slot_next  = free_slot_reg;
        wake_next       = wake_reg;
        clr_next        = clr_reg;
        wake_out_next   = wake_out_reg;
        status_out_next = status_out_reg;
        in_stall        = (state_reg != ST_IDLE);

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sub_vld_next          = sub_valid;
                    sub_next.waiter       = sub_waiter;
                    sub_next.mask         = sub_mask;
                    sub_next.expect_val   = sub_expect;
                    sensor_next           = sensor_word;
                    dup_next              = 1'b0;
                    have_free_next        = 1'b0;
                    free_slot_next        = '0;
                    wake_next             = '0;
                    clr_next              = '0;
                    cnt_next              = '0;
                    state_next            = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                if (cnt_reg != CNT_W'(TABLE_DEPTH))
                begin
                    rd_en       = 1'b1;
                    rd_vld_next = 1'b1;
                    cnt_next    = cnt_reg + CNT_W'(1);
                end
                else
                begin
                    // last slot's data is handled below in this cycle
                    state_next = ST_FINISH;
                end

                // data of the slot read last cycle
                if (rd_vld_reg)
                begin
                    if (occ_reg[rd_slot_reg])
                    begin
                        if (slot_dup)
                        begin
                            dup_next = 1'b1;
                        end
                        if (slot_match)
                        begin
                            wake_next = wake_next
                                | (WAKE_W'(1) << (rd_data_reg.waiter - WAITER_W'(1)));
                            clr_next[rd_slot_reg] = 1'b1;
                        end
                    end
                    else if (!have_free_reg)
                    begin
                        have_free_next = 1'b1;
                        free_slot_next = rd_slot_reg;
                    end
                end
            end

            ST_FINISH:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    occ_next        = occ_reg & ~clr_reg;
                    wake_out_next   = wake_reg;
                    status_out_next = SUB_NONE;
                    if (sub_vld_reg && waiter_ok)
                    begin
                        priority if (dup_reg)
                        begin
                            status_out_next = SUB_DUP;
                        end
                        else if (!have_free_reg)
                        begin
                            status_out_next = SUB_FULL;
                        end
                        else
                        begin
                            status_out_next = SUB_STORED;
                            if (new_match)
                            begin
                                // wakes at once, slot stays empty
                                wake_out_next = wake_reg
                                    | (WAKE_W'(1) << (sub_reg.waiter - WAITER_W'(1)));
                            end
                            else
                            begin
                                mem_we                  = 1'b1;
                                occ_next[free_slot_reg] = 1'b1;
                            end
                        end
                    end
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_vld_reg    <= 1'b0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_vld_reg    <= rd_vld_next;
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sub_vld_reg    <= sub_vld_next;
        sub_reg        <= sub_next;
        sensor_reg     <= sensor_next;
        dup_reg        <= dup_next;
        have_free_reg  <= have_free_next;
        free_slot_reg  <= free_slot_next;
        wake_reg       <= wake_next;
        clr_reg        <= clr_next;
        wake_out_reg   <= wake_out_next;
        status_out_reg <= status_out_next;
    end

    // single-port entry memory with a registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[free_slot_reg] <= sub_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_slot_reg <= rd_addr;
        end
    end

    assign out_valid   = out_valid_reg;
    assign wake_vector = wake_out_reg;
    assign sub_status  = status_out_reg;

endmodule

// ===== rtl/swst_checker.sv =====
// Port-level checks for the sensor wait subscription table, bound to the top.
// Depends on swst_pkg and sensor_wait_subscription_table.
`timescale 1ns / 1ps

module swst_props (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [swst_pkg::WAKE_W-1:0]   wake_vector,
    input logic [1:0]                    sub_status
);
    import swst_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(wake_vector)
            && $stable(sub_status))
        else $error("result beat changed while stalled");

    // an accepted beat keeps the input stalled as the sweep begins
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall ##1 in_stall)
        else $error("input taken again during a sweep");

    // a new result only appears at the end of a sweep
    a_result_from_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without a sweep");

endmodule

bind sensor_wait_subscription_table swst_props u_swst_props (.*);

// ===== tb/swst_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sensor wait subscription table: keeps a shadow slot table,
// predicts each period's wake vector and status, and compares result beats.
// Depends on swst_pkg.

module swst_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_stall,
    input  logic                          sub_valid,
    input  logic [swst_pkg::WAITER_W-1:0] sub_waiter,
    input  logic [swst_pkg::WORD_W-1:0]   sub_mask,
    input  logic [swst_pkg::WORD_W-1:0]   sub_expect,
    input  logic [swst_pkg::WORD_W-1:0]   sensor_word,
    input  logic                          out_valid,
    input  logic                          out_stall,
    input  logic [swst_pkg::WAKE_W-1:0]   wake_vector,
    input  logic [1:0]                    sub_status,
    output int                            fail_count,
    output int                            pending,
    output int                            checked
);
    import swst_pkg::*;

    typedef struct packed {
        logic [WAKE_W-1:0] wake;
        status_t           status;
    } period_result_t;

    logic [WAITER_W-1:0] shadow_waiter [TABLE_DEPTH];
    logic [WORD_W-1:0]   shadow_mask   [TABLE_DEPTH];
    logic [WORD_W-1:0]   shadow_expect [TABLE_DEPTH];
    period_result_t      awaited_results [$];

    function automatic status_t add_subscription(input logic [WAITER_W-1:0] waiter,
                                                 input logic [WORD_W-1:0] mask,
                                                 input logic [WORD_W-1:0] expect_val);
        int free_slot;
        free_slot = -1;
        if (waiter == '0 || waiter > WAITER_MAX)
        begin
            return SUB_NONE;
        end
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            if (shadow_waiter[s] != '0)
            begin
                if (shadow_waiter[s] == waiter && shadow_mask[s] == mask &&
                    shadow_expect[s] == expect_val)
                begin
                    return SUB_DUP;
                end
            end
            else if (free_slot < 0)
            begin
                free_slot = s;
            end
        end
        if (free_slot < 0)
        begin
            return SUB_FULL;
        end
        shadow_waiter[free_slot] = waiter;
        shadow_mask[free_slot]   = mask;
        shadow_expect[free_slot] = expect_val;
        return SUB_STORED;
    endfunction

    // One polling period: optional store first, then sweep every live slot.
    function automatic period_result_t poll_table(input logic sub_on,
                                                  input logic [WAITER_W-1:0] waiter,
                                                  input logic [WORD_W-1:0] mask,
                                                  input logic [WORD_W-1:0] expect_val,
                                                  input logic [WORD_W-1:0] sensors);
        period_result_t r;
        r.wake   = '0;
        r.status = SUB_NONE;
        if (sub_on)
        begin
            r.status = add_subscription(waiter, mask, expect_val);
        end
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            if (shadow_waiter[s] != '0 && shadow_waiter[s] <= WAITER_MAX &&
                (sensors & shadow_mask[s]) == shadow_expect[s])
            begin
                r.wake = r.wake | (WAKE_W'(1) << (shadow_waiter[s] - 1));
                shadow_waiter[s] = '0;
                shadow_mask[s]   = '0;
                shadow_expect[s] = '0;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        period_result_t want;
        int errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int s = 0; s < TABLE_DEPTH; s++)
            begin
                shadow_waiter[s] = '0;
                shadow_mask[s]   = '0;
                shadow_expect[s] = '0;
            end
            awaited_results.delete();
            fail_count <= 0;
            pending    <= 0;
            checked    <= 0;
        end
        else
        begin
            // result side first: a beat at this edge can't belong to an input at this edge
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result beat with nothing outstanding, expected none, got wake %b status %0d",
                             $time, wake_vector, sub_status);
                    errs++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (wake_vector !== want.wake)
                    begin
                        $display("%0t: wake_vector expected %b, got %b",
                                 $time, want.wake, wake_vector);
                        errs++;
                    end
                    if (sub_status !== want.status)
                    begin
                        $display("%0t: sub_status expected %0d, got %0d",
                                 $time, want.status, sub_status);
                        errs++;
                    end
                end
                checked <= checked + 1;
            end
            if (in_valid && !in_stall)
            begin
                awaited_results.push_back(poll_table(sub_valid, sub_waiter, sub_mask,
                                                     sub_expect, sensor_word));
            end
            fail_count <= fail_count + errs;
            pending    <= awaited_results.size();
        end
    end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the subscription table testbench: clock, reset, polling-period
// stimulus and result-side stalls, plus the verdict. Depends on swst_pkg,
// swst_checker and the sensor_wait_subscription_table RTL.

module tb_top;
    import swst_pkg::*;

    localparam int RANDOM_PERIODS = 1250;
    // Set many times over a run in which every beat takes its slowest legal
    // idle gap, busy sweep and result-side stall.
    localparam int CYCLE_LIMIT    = 400000;
    // Margin after drain, on top of a full accept-to-result sweep.
    localparam int DRAIN_CYCLES   = TABLE_DEPTH + 2 + 8;

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                sub_valid   = 1'b0;
    logic [WAITER_W-1:0] sub_waiter  = '0;
    logic [WORD_W-1:0]   sub_mask    = '0;
    logic [WORD_W-1:0]   sub_expect  = '0;
    logic [WORD_W-1:0]   sensor_word = '0;
    logic                out_stall   = 1'b0;
    wire                 in_stall;
    wire                 out_valid;
    wire [WAKE_W-1:0]    wake_vector;
    wire [1:0]           sub_status;

    int fail_count;
    int pending;
    int checked;
    int cycles       = 0;
    int periods_sent = 0;
    int subs_sent    = 0;

    // While calm is set neither side inserts idle or stall cycles.
    logic calm = 1'b0;

    // A few fixed sensor patterns per run; most subscriptions expect one of
    // them under their mask, so entries actually get matched and cleared.
    logic [WORD_W-1:0] pattern [4];

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    sensor_wait_subscription_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sub_valid   (sub_valid),
        .sub_waiter  (sub_waiter),
        .sub_mask    (sub_mask),
        .sub_expect  (sub_expect),
        .sensor_word (sensor_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .wake_vector (wake_vector),
        .sub_status  (sub_status)
    );

    swst_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sub_valid   (sub_valid),
        .sub_waiter  (sub_waiter),
        .sub_mask    (sub_mask),
        .sub_expect  (sub_expect),
        .sensor_word (sensor_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .wake_vector (wake_vector),
        .sub_status  (sub_status),
        .fail_count  (fail_count),
        .pending     (pending),
        .checked     (checked)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic int pick_gap();
        return calm ? 0 : $urandom_range(0, 9);
    endfunction

    // Drive one polling period at the falling edge and hold it until the
    // block takes the beat (valid high, stall low at a rising edge).
    task automatic send_period(input logic                sub_on,
                               input logic [WAITER_W-1:0] waiter,
                               input logic [WORD_W-1:0]   mask,
                               input logic [WORD_W-1:0]   expect_val,
                               input logic [WORD_W-1:0]   sensors);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        sub_valid   <= sub_on;
        sub_waiter  <= waiter;
        sub_mask    <= mask;
        sub_expect  <= expect_val;
        sensor_word <= sensors;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        periods_sent++;
        if (sub_on)
        begin
            subs_sent++;
        end
    endtask

    // Result side: per beat, stall for a random number of cycles, then take it.
    initial
    begin : result_side
        int hold;
        @(posedge rst_n);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
            @(negedge clk);
        end
    end

    initial
    begin : stimulus
        logic                sub_on;
        logic [WAITER_W-1:0] waiter;
        logic [WORD_W-1:0]   mask;
        logic [WORD_W-1:0]   expect_val;
        logic [WORD_W-1:0]   sensors;
        logic [WORD_W-1:0]   pat;
        logic [WAITER_W-1:0] last_waiter;
        logic [WORD_W-1:0]   last_mask;
        logic [WORD_W-1:0]   last_expect;
        logic                have_last;
        logic                dead;
        int                  dead_left;
        int                  pick;

        have_last = 1'b0;
        dead_left = 2;
        for (int k = 0; k < 4; k++)
        begin
            pattern[k] = $urandom;
        end

        // reset held from the start, released at a falling edge
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // ---- directed part ----
        // no subscription on an empty table, all sensors high
        send_period(1'b0, 3'd1, '1, '1, '1);
        // waiter ids outside 1..5 are ignored
        send_period(1'b1, 3'd0, 32'h0000_00FF, 32'h0000_000F, 32'h0000_000F);
        send_period(1'b1, 3'd6, 32'h0000_00FF, 32'h0000_000F, 32'h0000_000F);
        send_period(1'b1, 3'd7, 32'h0000_00FF, 32'h0000_000F, 32'h0000_000F);
        // stored and matched in the same period
        send_period(1'b1, 3'd1, '1, '1, '1);
        // waiter 2 waits for all-zero sensors; then an exact duplicate
        send_period(1'b1, 3'd2, '1, '0, 32'h0000_0001);
        send_period(1'b1, 3'd2, '1, '0, 32'h0000_0001);
        // same waiter and mask, other expectation: a separate entry
        send_period(1'b1, 3'd2, '1, 32'h0000_0001, 32'h0000_0002);
        // sensors all low: first waiter-2 entry fires, the other stays
        send_period(1'b0, 3'd0, '0, '0, '0);
        // expectation outside the mask: never matches, parked for good
        send_period(1'b1, 3'd3, 32'h0000_00FF, 32'h0000_0100, '1);
        // empty mask matches on any sensor word
        send_period(1'b1, 3'd1, '0, '0, 32'h1234_5678);
        // fill the rest of the table; waiter 4 gets two entries that both fire later
        for (int k = 1; k <= 5; k++)
        begin
            send_period(1'b1, 3'(k), '1, 32'hA5A5_A5A5, '0);
        end
        send_period(1'b1, 3'd4, 32'hF0F0_F0F0, 32'hA0A0_A0A0, '0);
        // table full: a new entry is dropped, a duplicate still reads as duplicate
        send_period(1'b1, 3'd5, '1, '0, 32'h8000_0000);
        send_period(1'b1, 3'd1, '1, 32'hA5A5_A5A5, 32'h8000_0000);
        // one sensor word wakes all five waiters, waiter 4 twice over
        send_period(1'b0, 3'd0, '0, '0, 32'hA5A5_A5A5);
        // remaining waiter-2 entry
        send_period(1'b0, 3'd0, '0, '0, 32'h0000_0001);
        // top waiter id with full-width expectation
        send_period(1'b1, 3'd5, '1, '1, '0);
        send_period(1'b0, 3'd0, '0, '0, '1);

        // ---- random part ----
        for (int n = 0; n < RANDOM_PERIODS; n++)
        begin
            if ($urandom_range(0, 59) == 0)
            begin
                calm = !calm;
            end
            sub_on = ($urandom_range(0, 9) < 6);
            waiter = 3'($urandom_range(1, 5));
            if ($urandom_range(0, 19) == 0)
            begin
                pick   = $urandom_range(0, 2);
                waiter = (pick == 0) ? 3'd0 : 3'(5 + pick);
            end
            pat = pattern[$urandom_range(0, 3)];
            case ($urandom_range(0, 4))
                0:
                begin
                    // one or two bits; random expectation within them
                    mask       = (32'd1 << $urandom_range(0, 31)) |
                                 (32'd1 << $urandom_range(0, 31));
                    expect_val = $urandom & mask;
                end
                1:
                begin
                    mask       = $urandom & $urandom;
                    expect_val = pat & mask;
                end
                2:
                begin
                    mask       = $urandom;
                    expect_val = pat & mask;
                end
                3:
                begin
                    mask       = '1;
                    expect_val = pat;
                end
                default:
                begin
                    mask       = ($urandom_range(0, 49) == 0) ? '0 : ($urandom | $urandom);
                    expect_val = pat & mask;
                end
            endcase
            // rarely an expectation that can never match (these stay for good)
            dead = 1'b0;
            if (dead_left > 0 && $urandom_range(0, 399) == 0)
            begin
                if (mask == '1)
                begin
                    mask = 32'hFFFF_FFFE;
                end
                expect_val = expect_val | ~mask;
                dead       = 1'b1;
                dead_left--;
            end
            else if (have_last && $urandom_range(0, 6) == 0)
            begin
                waiter     = last_waiter;
                mask       = last_mask;
                expect_val = last_expect;
            end
            sensors = ($urandom_range(0, 9) < 7) ? pattern[$urandom_range(0, 3)] : $urandom;
            if ($urandom_range(0, 9) == 0)
            begin
                sensors = sensors ^ (32'd1 << $urandom_range(0, 31));
            end
            send_period(sub_on, waiter, mask, expect_val, sensors);
            if (sub_on && !dead)
            begin
                last_waiter = waiter;
                last_mask   = mask;
                last_expect = expect_val;
                have_last   = 1'b1;
            end
        end
        in_valid <= 1'b0;

        // let every outstanding result come back, then a little more
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Ran %0d polling periods (%0d with a subscription); %0d result beats compared",
                 periods_sent, subs_sent, checked);
        $display("with random idle and stall cycles on both channels.");
        if (fail_count == 0 && pending == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/swst_pkg.sv
rtl/sensor_wait_subscription_table.sv
rtl/swst_checker.sv
tb/swst_checker.sv
tb/tb_top.sv
